### rtl/core/hybrid_task_dispatcher_unit_defines.svh
// Assertion helpers for the task dispatcher.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef HYBRID_TASK_DISPATCHER_UNIT_DEFINES_SVH
`define HYBRID_TASK_DISPATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define HTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hybtd: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define HTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hybtd: next-cycle check failed");

`endif

### rtl/core/hybtd_pkg.sv
`default_nettype none

package hybtd_pkg;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_TICK  = 2'd1;
    localparam t_op OP_EVENT = 2'd2;

    typedef logic [1:0] t_policy;
    localparam t_policy POL_ROUND_ROBIN = 2'd0;
    localparam t_policy POL_PRIORITY    = 2'd1;
    localparam t_policy POL_HYBRID      = 2'd2;

    localparam logic [1:0] FLAG_RX = 2'b01;
    localparam logic [1:0] FLAG_EQ = 2'b10;

    typedef struct packed {
        t_op        op;
        logic [2:0] task_index;
        logic [3:0] task_priority;
        logic [7:0] release_period;
        logic [7:0] iteration_budget;
        logic       task_kind;
        logic [1:0] wait_mask;
        logic [1:0] event_bits;
    } t_in_item;

    typedef struct packed {
        logic        granted;
        logic [2:0]  granted_task;
        logic        by_priority;
        logic        task_finished;
        logic        all_done;
        logic [31:0] tick_now;
        logic [1:0]  flags_now;
    } t_out_item;

    // one row of the task RAM
    typedef struct packed {
        logic [3:0]  prio_lvl;
        logic [7:0]  period;
        logic [31:0] rel_time;
        logic [7:0]  iters_left;
        logic        kind;
        logic [1:0]  wait_mask;
    } t_entry;

    // sequencer to picker controls
    typedef struct packed {
        logic clear;
        logic eval;
        logic use_prio;
    } t_pick_ctl;

endpackage

`default_nettype wire

### rtl/core/hybtd_entry_ram.sv
`default_nettype none

module hybtd_entry_ram
    import hybtd_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/core/hybtd_pick.sv
`default_nettype none

module hybtd_pick
    import hybtd_pkg::*;
#(
    parameter int PRIORITY_LEVELS = 10,
    parameter int IW              = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_pick_ctl     i_ctl,
    input  wire logic [IW-1:0] i_idx,
    input  wire t_entry        i_entry,
    input  wire logic          i_done,
    input  wire logic [31:0]   i_tick,
    input  wire logic [1:0]    i_flags,
    output logic               o_found,
    output logic [IW-1:0]      o_win_idx,
    output t_entry             o_win_entry
);

    localparam logic [4:0] PL_W = PRIORITY_LEVELS[4:0];

    logic          r_found;
    logic [IW-1:0] r_win_idx;
    t_entry        r_win_entry;

    logic ready;
    logic prio_ok;
    logic take;

    always_comb begin
        ready = !i_done && (i_tick >= i_entry.rel_time) &&
                ((i_entry.wait_mask == 2'b00) || ((i_flags & i_entry.wait_mask) != 2'b00));
        prio_ok = ({1'b0, i_entry.prio_lvl} < PL_W);
        // priority scan runs from index 0 upward, so a strict compare keeps the lowest index
        if (i_ctl.use_prio) begin
            take = ready && prio_ok && (!r_found || (i_entry.prio_lvl < r_win_entry.prio_lvl));
        end else begin
            take = ready && !r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.eval && take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && i_ctl.eval && take) begin
            r_win_idx   <= i_idx;
            r_win_entry <= i_entry;
        end
    end

    assign o_found     = r_found;
    assign o_win_idx   = r_win_idx;
    assign o_win_entry = r_win_entry;

endmodule

`default_nettype wire

### rtl/core/hybrid_task_dispatcher_unit.sv
// Channel   Direction  Handshake               Payload
// in        to block   i_in_valid/o_in_stall    i_in_item  (t_in_item)
// out       from block o_out_valid/i_out_stall  o_out_item (t_out_item)
// cfg       to block   i_cfg_valid/o_cfg_ready  i_cfg_data (policy)
//
// A load, event or ignored item, or a tick with every entry done, goes from S_IDLE, which
// takes it, to S_RESULT, which hands off the result once the output is free, and back.
// Any other tick goes through S_SCAN, where the task RAM read port visits one entry per
// cycle, then S_DRAIN drains the read, S_WB writes the winner back, S_RESULT hands off.
// Reset (i_rst_n low, synchronous) marks every entry done; RAM rows need no clearing.
// A stalled output holds its result while the next item is already taken and worked on.
`default_nettype none

`include "hybrid_task_dispatcher_unit_defines.svh"

module hybrid_task_dispatcher_unit
    import hybtd_pkg::*;
#(
    parameter int TASK_COUNT      = 8,
    parameter int PRIORITY_LEVELS = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_data
);

    localparam int IW   = $clog2(TASK_COUNT);
    localparam int TCM1 = TASK_COUNT - 1;
    localparam logic [IW:0]   TC_W   = TASK_COUNT[IW:0];
    localparam logic [IW-1:0] LAST_K = TCM1[IW-1:0];

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_WB     = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_policy             r_policy, n_policy;
    logic [31:0]         r_tick, n_tick;
    logic [1:0]          r_flags, n_flags;
    logic [IW-1:0]       r_cursor, n_cursor;
    logic [TASK_COUNT-1:0] r_done, n_done;
    logic                r_use_prio, n_use_prio;
    logic [IW-1:0]       r_base, n_base;
    logic [IW-1:0]       r_k, n_k;
    logic                r_rd_vld;
    logic [IW-1:0]       r_eval_idx;
    logic                r_granted, n_granted;
    logic [IW-1:0]       r_gtask, n_gtask;
    logic                r_byprio, n_byprio;
    logic                r_finished, n_finished;
    logic                r_out_vld, n_out_vld;
    t_out_item           r_out_item, n_out_item;

    logic          in_xfer;
    logic          out_free;
    logic [31:0]   load_ext;
    logic          load_ok;
    logic [IW:0]   addr_sum;
    logic [IW:0]   addr_wrap;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    t_entry        rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic          tick_use_prio;
    logic [7:0]    iters_next;
    logic [31:0]   gtask_ext;
    t_pick_ctl     pick_ctl;
    logic          win_found;
    logic [IW-1:0] win_idx;
    t_entry        win_entry;
    logic          nogrant_clean;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;

    assign load_ext = 32'(i_in_item.task_index);
    assign load_ok  = (load_ext < 32'(TASK_COUNT));

    // scan address: base + k, wrapped into the table
    assign addr_sum  = {1'b0, r_base} + {1'b0, r_k};
    assign addr_wrap = (addr_sum >= TC_W) ? (addr_sum - TC_W) : addr_sum;
    assign rd_addr   = addr_wrap[IW-1:0];
    assign rd_en     = (r_state == S_SCAN);

    assign iters_next = win_entry.iters_left - 8'd1;
    assign gtask_ext  = 32'(r_gtask);

    always_comb begin
        case (r_policy)
            POL_ROUND_ROBIN: tick_use_prio = 1'b0;
            POL_PRIORITY:    tick_use_prio = 1'b1;
            default:         tick_use_prio = (r_flags != 2'b00);
        endcase
    end

    assign pick_ctl.clear    = (r_state == S_IDLE);
    assign pick_ctl.eval     = r_rd_vld;
    assign pick_ctl.use_prio = r_use_prio;

    always_comb begin
        n_state    = r_state;
        n_policy   = r_policy;
        n_tick     = r_tick;
        n_flags    = r_flags;
        n_cursor   = r_cursor;
        n_done     = r_done;
        n_use_prio = r_use_prio;
        n_base     = r_base;
        n_k        = r_k;
        n_granted  = r_granted;
        n_gtask    = r_gtask;
        n_byprio   = r_byprio;
        n_finished = r_finished;
        n_out_vld  = r_out_vld;
        n_out_item = r_out_item;
        wr_en      = 1'b0;
        wr_addr    = load_ext[IW-1:0];
        wr_data    = '{prio_lvl:   i_in_item.task_priority,
                       period:     i_in_item.release_period,
                       rel_time:   32'd0,
                       iters_left: i_in_item.iteration_budget,
                       kind:       i_in_item.task_kind,
                       wait_mask:  i_in_item.wait_mask};

        if (i_cfg_valid && o_cfg_ready) begin
            n_policy = i_cfg_data;
        end

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_granted  = 1'b0;
                    n_gtask    = '0;
                    n_byprio   = 1'b0;
                    n_finished = 1'b0;
                    n_state    = S_RESULT;
                    case (i_in_item.op)
                        OP_LOAD: begin
                            if (load_ok) begin
                                wr_en           = 1'b1;
                                n_done[wr_addr] = 1'b0;
                            end
                        end
                        OP_TICK: begin
                            if (!(&r_done)) begin
                                n_tick     = r_tick + 32'd1;
                                n_use_prio = tick_use_prio;
                                n_base     = tick_use_prio ? '0 : r_cursor;
                                n_k        = '0;
                                n_state    = S_SCAN;
                            end
                        end
                        OP_EVENT: begin
                            n_flags = r_flags | i_in_item.event_bits;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                n_k = r_k + 1'b1;
                if (r_k == LAST_K) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_WB;
            end
            S_WB: begin
                if (win_found) begin
                    wr_en              = 1'b1;
                    wr_addr            = win_idx;
                    wr_data            = win_entry;
                    wr_data.rel_time   = r_tick + 32'(win_entry.period);
                    wr_data.iters_left = iters_next;
                    n_granted          = 1'b1;
                    n_gtask            = win_idx;
                    n_byprio           = r_use_prio;
                    if (iters_next == 8'd0) begin
                        n_done[win_idx] = 1'b1;
                        n_finished      = 1'b1;
                        n_flags         = r_flags & ~(win_entry.kind ? FLAG_EQ : FLAG_RX);
                    end
                    if (!r_use_prio) begin
                        n_cursor = (win_idx == LAST_K) ? '0 : win_idx + 1'b1;
                    end
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_item = '{granted:       r_granted,
                                   granted_task:  gtask_ext[2:0],
                                   by_priority:   r_byprio,
                                   task_finished: r_finished,
                                   all_done:      &r_done,
                                   tick_now:      r_tick,
                                   flags_now:     r_flags};
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_policy   <= POL_HYBRID;
            r_tick     <= '0;
            r_flags    <= '0;
            r_cursor   <= '0;
            r_done     <= '1;
            r_use_prio <= 1'b0;
            r_k        <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_policy   <= n_policy;
            r_tick     <= n_tick;
            r_flags    <= n_flags;
            r_cursor   <= n_cursor;
            r_done     <= n_done;
            r_use_prio <= n_use_prio;
            r_k        <= n_k;
            r_rd_vld   <= rd_en;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_eval_idx <= rd_addr;
        r_granted  <= n_granted;
        r_gtask    <= n_gtask;
        r_byprio   <= n_byprio;
        r_finished <= n_finished;
        r_out_item <= n_out_item;
    end

    hybtd_entry_ram #(
        .DEPTH (TASK_COUNT),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    hybtd_pick #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .IW              (IW)
    ) u_pick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (pick_ctl),
        .i_idx       (r_eval_idx),
        .i_entry     (rd_data),
        .i_done      (r_done[r_eval_idx]),
        .i_tick      (r_tick),
        .i_flags     (r_flags),
        .o_found     (win_found),
        .o_win_idx   (win_idx),
        .o_win_entry (win_entry)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    assign nogrant_clean = !r_out_item.by_priority && !r_out_item.task_finished &&
                           (r_out_item.granted_task == 3'd0);

    // an ungranted result carries no task, no priority mark and no finish
    `HTD_ASSERT_NOW(a_nogrant_clean, r_out_vld && !r_out_item.granted, nogrant_clean)
    // the tick counter moves only on a tick transfer
    `HTD_ASSERT_NEXT(a_tick_hold, !(in_xfer && (i_in_item.op == OP_TICK)), $stable(r_tick))
    // the RAM is written only on a load transfer or at write-back
    `HTD_ASSERT_NOW(a_wr_phase, wr_en, (r_state == S_IDLE) || (r_state == S_WB))

endmodule

`default_nettype wire

### dv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hybtd_pkg::*;

    localparam int TASK_COUNT      = 8;
    localparam int PRIORITY_LEVELS = 10;
    localparam t_policy POL_SPARE  = 2'd3;   // decodes like hybrid
    localparam t_op     OP_SPARE   = 2'd3;   // ignored by the block

    class dispatch_scoreboard;
        logic [3:0]  prio_lvl [TASK_COUNT];
        logic [7:0]  period   [TASK_COUNT];
        logic [31:0] rel_time [TASK_COUNT];
        logic [7:0]  iters    [TASK_COUNT];
        logic        kind     [TASK_COUNT];
        logic [1:0]  wait_msk [TASK_COUNT];
        bit          done     [TASK_COUNT];
        logic [31:0] tick;
        logic [1:0]  flags;
        logic [2:0]  cursor;
        t_policy     policy;
        t_out_item   expected_status[$];
        int          errors;
        int          n_checked;
        int          n_rr_grants;
        int          n_prio_grants;
        int          n_finished;

        function new();
            for (int i = 0; i < TASK_COUNT; i++) begin
                prio_lvl[i] = '0;
                period[i]   = '0;
                rel_time[i] = '0;
                iters[i]    = '0;
                kind[i]     = 1'b0;
                wait_msk[i] = '0;
                done[i]     = 1'b1;
            end
            tick          = '0;
            flags         = '0;
            cursor        = '0;
            policy        = POL_HYBRID;
            errors        = 0;
            n_checked     = 0;
            n_rr_grants   = 0;
            n_prio_grants = 0;
            n_finished    = 0;
        endfunction

        function bit busy();
            return expected_status.size() != 0;
        endfunction

        function bit table_idle();
            for (int i = 0; i < TASK_COUNT; i++) begin
                if (!done[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit entry_ready(int i);
            if (done[i]) return 1'b0;
            if (tick < rel_time[i]) return 1'b0;
            if (wait_msk[i] != 0 && (flags & wait_msk[i]) == 0) return 1'b0;
            return 1'b1;
        endfunction

        // Apply one accepted input item and queue the status it must produce.
        function void note_item(t_in_item it);
            t_out_item r;
            int        win;
            int        idx;
            bit        use_prio;
            r   = '0;
            win = -1;
            case (it.op)
                OP_LOAD: begin
                    idx           = int'(it.task_index);
                    prio_lvl[idx] = it.task_priority;
                    period[idx]   = it.release_period;
                    rel_time[idx] = '0;
                    iters[idx]    = it.iteration_budget;
                    kind[idx]     = it.task_kind;
                    wait_msk[idx] = it.wait_mask;
                    done[idx]     = 1'b0;
                end
                OP_TICK: begin
                    if (!table_idle()) begin
                        tick = tick + 32'd1;
                        if (policy == POL_ROUND_ROBIN)
                            use_prio = 1'b0;
                        else if (policy == POL_PRIORITY)
                            use_prio = 1'b1;
                        else
                            use_prio = (flags != 0);
                        if (use_prio) begin
                            for (int p = 0; p < PRIORITY_LEVELS; p++) begin
                                for (int i = 0; i < TASK_COUNT; i++) begin
                                    if (win < 0 && prio_lvl[i] == p && entry_ready(i)) win = i;
                                end
                            end
                        end else begin
                            for (int k = 0; k < TASK_COUNT; k++) begin
                                idx = (cursor + k) % TASK_COUNT;
                                if (win < 0 && entry_ready(idx)) win = idx;
                            end
                            if (win >= 0) cursor = 3'((win + 1) % TASK_COUNT);
                        end
                        if (win >= 0) begin
                            r.granted      = 1'b1;
                            r.granted_task = 3'(win);
                            r.by_priority  = use_prio;
                            rel_time[win]  = tick + {24'd0, period[win]};
                            iters[win]     = iters[win] - 8'd1;
                            if (iters[win] == 0) begin
                                done[win]       = 1'b1;
                                r.task_finished = 1'b1;
                                flags = flags & ~(kind[win] ? FLAG_EQ : FLAG_RX);
                            end
                        end
                    end
                end
                OP_EVENT: flags = flags | it.event_bits;
                default: ;
            endcase
            r.all_done  = table_idle();
            r.tick_now  = tick;
            r.flags_now = flags;
            expected_status.push_back(r);
        endfunction

        task report_mismatch(string msg);
            // keep the log bounded when the block is badly broken
            if (errors < 100) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] exp);
            if (got !== exp)
                report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                          n_checked, name, got, exp));
        endtask

        task check_status(t_out_item got);
            t_out_item exp;
            if (expected_status.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %h", got));
                return;
            end
            exp = expected_status.pop_front();
            compare_field("granted",       32'(got.granted),       32'(exp.granted));
            compare_field("granted_task",  32'(got.granted_task),  32'(exp.granted_task));
            compare_field("by_priority",   32'(got.by_priority),   32'(exp.by_priority));
            compare_field("task_finished", 32'(got.task_finished), 32'(exp.task_finished));
            compare_field("all_done",      32'(got.all_done),      32'(exp.all_done));
            compare_field("tick_now",      got.tick_now,           exp.tick_now);
            compare_field("flags_now",     32'(got.flags_now),     32'(exp.flags_now));
            if (exp.granted && exp.by_priority) n_prio_grants++;
            else if (exp.granted) n_rr_grants++;
            if (exp.task_finished) n_finished++;
            n_checked++;
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_data  = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       o_cfg_ready;

    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int n_sent          = 0;

    dispatch_scoreboard sb = new();

    always #2 clk = ~clk;

    hybrid_task_dispatcher_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) sb.check_status(o_out_item);
    end

    function automatic t_in_item mk(t_op op, int idx, int pr, int per, int bud, int kd,
                                    int wm, int ev);
        t_in_item it;
        it.op               = op;
        it.task_index       = 3'(idx);
        it.task_priority    = 4'(pr);
        it.release_period   = 8'(per);
        it.iteration_budget = 8'(bud);
        it.task_kind        = 1'(kd);
        it.wait_mask        = 2'(wm);
        it.event_bits       = 2'(ev);
        return it;
    endfunction

    // Mostly short-lived tasks with small periods so entries finish and flags get cleared;
    // unused fields stay random.
    function automatic t_in_item random_item();
        logic [31:0] raw;
        t_in_item it;
        int       r;
        raw = $urandom;
        it  = raw[$bits(t_in_item)-1:0];
        r   = $urandom_range(99);
        if (r < 25) begin
            it.op = OP_LOAD;
            if ($urandom_range(99) < 85) it.task_priority = 4'($urandom_range(PRIORITY_LEVELS - 1));
            r = $urandom_range(99);
            if (r < 70)      it.release_period = 8'($urandom_range(4));
            else if (r < 95) it.release_period = 8'($urandom_range(20));
            r = $urandom_range(99);
            if (r < 80)      it.iteration_budget = 8'($urandom_range(4, 1));
            else if (r < 95) it.iteration_budget = 8'($urandom_range(255, 1));
            else             it.iteration_budget = 8'd0;
            if ($urandom_range(1)) it.wait_mask = 2'd0;
        end else if (r < 75) begin
            it.op = OP_TICK;
        end else if (r < 93) begin
            it.op = OP_EVENT;
        end else begin
            it.op = OP_SPARE;
        end
        return it;
    endfunction

    task send_item(t_in_item it);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (o_in_stall);
        sb.note_item(it);
        if (it.op != OP_SPARE) n_sent++;
    endtask

    // Drain everything in flight, then let the block settle before touching the register.
    task write_policy(t_policy v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.busy()) @(posedge clk);
        repeat (TASK_COUNT + 8) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!o_cfg_ready);
        sb.policy = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task run_phase(t_policy pol, int s_idle, int r_idle, int count);
        int n;
        t_in_item it;
        write_policy(pol);
        sender_idle_pct = s_idle;
        recv_idle_pct   = r_idle;
        n = 0;
        while (n < count) begin
            it = random_item();
            send_item(it);
            if (it.op != OP_SPARE) n++;
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset policy (hybrid)
        sender_idle_pct = 11;
        recv_idle_pct   = 80;
        send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));      // nothing pending
        send_item('1);                                    // spare op, all ones
        send_item(mk(OP_LOAD, 0, 0, 0, 1, 0, 0, 0));
        send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));      // finish, table empty again
        send_item(mk(OP_LOAD, 7, 15, 255, 255, 1, 3, 3));
        send_item(mk(OP_LOAD, 3, 9, 1, 0, 0, 0, 0));      // zero budget
        send_item(mk(OP_LOAD, 5, 10, 2, 2, 1, 1, 0));     // priority above the levels
        send_item(mk(OP_TICK, 7, 15, 255, 255, 1, 3, 3));
        send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_EVENT, 0, 0, 0, 0, 0, 0, 1));
        send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_EVENT, 7, 15, 255, 255, 1, 3, 2));
        send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_LOAD, 1, 0, 0, 1, 1, 2, 3));
        send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));      // finish clears the EQ flag
        send_item(mk(OP_EVENT, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_LOAD, 2, 4, 200, 1, 0, 2, 0));    // waits on a clear flag
        send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));

        run_phase(POL_ROUND_ROBIN, 11, 80, 150);
        run_phase(POL_PRIORITY,    80, 11, 150);
        run_phase(POL_HYBRID,       0,  0, 150);
        run_phase(POL_SPARE,        0,  0, 150);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.busy()) @(posedge clk);
        repeat (4 * TASK_COUNT) @(posedge clk);

        $display("Sent %0d items over all four policy settings; checked %0d results.",
                 n_sent, sb.n_checked);
        $display("Grants: %0d round-robin, %0d by priority; %0d tasks ran out; final tick %0d.",
                 sb.n_rr_grants, sb.n_prio_grants, sb.n_finished, sb.tick);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout: %0d results still outstanding", sb.expected_status.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+rtl/core
rtl/core/hybtd_pkg.sv
rtl/core/hybtd_entry_ram.sv
rtl/core/hybtd_pick.sv
rtl/core/hybrid_task_dispatcher_unit.sv
dv/tb.sv
